/* hw/rtl/pdsp_pkg.sv */
// shared types and constants for the phase delay stereo panner
`default_nettype none

package pdsp_pkg;

    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned PAN_W        = 9;
    localparam int unsigned RATE_W       = 18;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned CFG_DATA_W   = 18;
    localparam int unsigned PAN_SQ_W     = 2 * PAN_W - 1;
    localparam int unsigned PAN_SQ_SHIFT = 14;
    localparam int unsigned USEC_PER_SEC = 1000000;
    localparam int unsigned TAP_GROUP    = 8;
    localparam int unsigned OUT_FIFO_DEPTH = 8;
    localparam int unsigned OUT_PTR_W    = $clog2(OUT_FIFO_DEPTH);
    localparam int unsigned OUT_CNT_W    = $clog2(OUT_FIFO_DEPTH + 1);

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
    localparam logic [PAN_W-1:0]  PAN_RESET  = 9'd0;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_PAN  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE = 1'b1;

    // input beat kinds carried in tuser
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic push;
        logic flush;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/pdsp_cell.sv */
// one history cell: holds a sample, shifts it on, clears it on flush, gates it onto the tap buses
`default_nettype none

module pdsp_cell #(
    parameter int unsigned TAP_INDEX = 1,
    parameter int unsigned DLY_W     = 7
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire pdsp_pkg::cell_ctrl_t ctrl,
    input  wire  [DLY_W-1:0]          dly_l,
    input  wire  [DLY_W-1:0]          dly_r,
    input  wire pdsp_pkg::sample_t    sample_in,
    output pdsp_pkg::sample_t         sample_out,
    output pdsp_pkg::sample_t         tap_l,
    output pdsp_pkg::sample_t         tap_r
);
    import pdsp_pkg::*;

    localparam logic [DLY_W-1:0] MY_DLY = DLY_W'(TAP_INDEX);

    sample_t sample_reg;
    sample_t sample_next;

    always_comb begin
        sample_next = sample_reg;
        if (ctrl.flush) begin
            sample_next = '0;
        end else if (ctrl.push) begin
            sample_next = sample_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;
    assign tap_l = (dly_l == MY_DLY) ? sample_reg : '0;
    assign tap_r = (dly_r == MY_DLY) ? sample_reg : '0;

endmodule

`default_nettype wire

/* hw/rtl/pdsp_delay_calc.sv */
// pipelined delay computation from pan position and mixing rate
`default_nettype none

module pdsp_delay_calc #(
    parameter int unsigned SHIFT_USEC = 333,
    parameter int unsigned HIST_DEPTH = 64,
    parameter int unsigned DLY_W      = 7
) (
    input  wire                              aclk,
    input  wire  [pdsp_pkg::PAN_W-1:0]       pan,
    input  wire  [pdsp_pkg::RATE_W-1:0]      rate,
    output logic [DLY_W-1:0]                 dly_l,
    output logic [DLY_W-1:0]                 dly_r
);
    import pdsp_pkg::*;

    localparam int unsigned XW       = RATE_W + $clog2(SHIFT_USEC + 1);
    localparam int unsigned RSHIFT   = XW + 20;
    localparam int unsigned MW       = RSHIFT - 19;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSHIFT) + 64'(USEC_PER_SEC) - 64'd1) / 64'(USEC_PER_SEC);
    localparam logic [MW-1:0] RECIP  = MW'(RECIP_FULL);
    localparam longint unsigned QMAX =
        (longint'((1 << RATE_W) - 1) * longint'(SHIFT_USEC)) / longint'(USEC_PER_SEC);
    localparam int unsigned QW       = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
    localparam int unsigned PW       = PAN_SQ_W + QW;
    localparam int unsigned PRW      = XW + MW;

    logic [PAN_W-1:0]    mag;
    logic [XW-1:0]       rate_x_reg;
    logic [PAN_SQ_W-1:0] sq1_reg;
    logic [PAN_SQ_W-1:0] sq2_reg;
    logic [2:0]          neg_reg;
    logic [PRW-1:0]      recip_prod;
    logic [QW-1:0]       max_shift_reg;
    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       dly_full;
    logic [DLY_W-1:0]    dly_sat;

    // magnitude of a negative pan is its two's complement
    assign mag = pan[PAN_W-1] ? ((~pan) + PAN_W'(1)) : pan;

    always_ff @(posedge aclk) begin
        rate_x_reg <= XW'(rate) * XW'(SHIFT_USEC);
        sq1_reg    <= PAN_SQ_W'(mag * mag);
        neg_reg[0] <= pan[PAN_W-1];
    end

    // floor divide by one million through a reciprocal wide enough to be exact
    assign recip_prod = PRW'(rate_x_reg) * PRW'(RECIP);

    always_ff @(posedge aclk) begin
        max_shift_reg <= QW'(recip_prod >> RSHIFT);
        sq2_reg       <= sq1_reg;
        neg_reg[1]    <= neg_reg[0];
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= PW'(sq2_reg) * PW'(max_shift_reg);
        neg_reg[2] <= neg_reg[1];
    end

    assign dly_full = prod_reg >> PAN_SQ_SHIFT;
    assign dly_sat  = (dly_full > PW'(HIST_DEPTH)) ? DLY_W'(HIST_DEPTH) : DLY_W'(dly_full);

    always_ff @(posedge aclk) begin
        dly_l <= neg_reg[2] ? '0 : dly_sat;
        dly_r <= neg_reg[2] ? dly_sat : '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/pdsp_out_fifo.sv */
// small show-ahead result queue in front of the master port
`default_nettype none

module pdsp_out_fifo #(
    parameter int unsigned DATA_W = 32
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  wire  [DATA_W-1:0] push_data,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [DATA_W-1:0] m_tdata
);
    import pdsp_pkg::*;

    logic [DATA_W-1:0]    store_reg [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 pop;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + OUT_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != OUT_CNT_W'(OUT_FIFO_DEPTH)))
        else $error("result queue overflow");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + OUT_CNT_W'(1)))
        else $error("result queue count lost a beat");

endmodule

`default_nettype wire

/* hw/rtl/phase_delay_stereo_panner.sv */
// top level: mono to stereo panner with a delayed side built from a chain of history cells
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: sample_in[15:0]; tuser: action (1 = flush)
//  m_       out  m_tvalid/m_tready    tdata: left_sample[15:0], right_sample[31:16]
//  cfg_     in   cfg_wen              cfg_addr: 0 pan, 1 rate; cfg_wdata[17:0]
//
// one beat per cycle sustained while s_tready is high; a result shows on m_ once its beat has
// passed the four delay math stages, the cell row tap, then the group merge into the result queue
// aresetn is synchronous; it zeroes the history cells and loads the register defaults
// s_tready follows a credit count against the eight-entry result queue, so a stalled
// m_ side keeps taking beats until eight push beats are in flight or waiting; flush beats give no result
`default_nettype none

module phase_delay_stereo_panner #(
    parameter int unsigned HISTORY_DEPTH = 64,
    parameter int unsigned SHIFT_USEC    = 333
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // sample_in[15:0]
    input  wire  [15:0]                        s_tdata,
    // action
    input  wire                                s_tuser,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // left_sample[15:0], right_sample[31:16]
    output logic [31:0]                        m_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  wire                                cfg_wen,
    input  wire  [pdsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [pdsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pdsp_pkg::*;

    localparam int unsigned DLY_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned NGROUP  = (HISTORY_DEPTH + TAP_GROUP - 1) / TAP_GROUP;
    localparam int unsigned NTAP    = NGROUP * TAP_GROUP;
    localparam int unsigned NSTG    = 4;

    logic [PAN_W-1:0]   pan_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [OUT_CNT_W-1:0] credit_reg;
    logic [OUT_CNT_W-1:0] credit_next;

    logic               in_acc;
    logic               out_acc;

    logic               stg_vld_reg    [NSTG];
    logic               stg_flush_reg  [NSTG];
    sample_t            stg_sample_reg [NSTG];

    logic [DLY_W-1:0]   dly_l;
    logic [DLY_W-1:0]   dly_r;
    cell_ctrl_t         cell_ctrl;

    sample_t            chain   [HISTORY_DEPTH + 1];
    sample_t            tap_l   [NTAP];
    sample_t            tap_r   [NTAP];

    sample_t            grp_l_next [NGROUP];
    sample_t            grp_r_next [NGROUP];
    sample_t            grp_l_reg  [NGROUP];
    sample_t            grp_r_reg  [NGROUP];
    logic               res_vld_reg;
    sample_t            res_cur_reg;
    logic               res_zero_l_reg;
    logic               res_zero_r_reg;

    sample_t            merged_l;
    sample_t            merged_r;
    sample_t            out_l;
    sample_t            out_r;

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;
    assign s_tready = (credit_reg < OUT_CNT_W'(OUT_FIFO_DEPTH));

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_reg  <= PAN_RESET;
            rate_reg <= RATE_RESET;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_PAN: begin
                    pan_reg <= cfg_wdata[PAN_W-1:0];
                end
                REG_RATE: begin
                    rate_reg <= cfg_wdata[RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // one credit per push beat in flight or waiting in the queue
    always_comb begin
        credit_next = credit_reg;
        if ((in_acc && (s_tuser == ACT_PUSH)) && !out_acc) begin
            credit_next = credit_reg + OUT_CNT_W'(1);
        end else if (out_acc && !(in_acc && (s_tuser == ACT_PUSH))) begin
            credit_next = credit_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // item stages that line up with the delay math
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                stg_vld_reg[i] <= 1'b0;
            end
        end else begin
            stg_vld_reg[0] <= in_acc;
            for (int i = 1; i < NSTG; i++) begin
                stg_vld_reg[i] <= stg_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        stg_flush_reg[0]  <= s_tuser;
        stg_sample_reg[0] <= sample_t'(s_tdata);
        for (int i = 1; i < NSTG; i++) begin
            stg_flush_reg[i]  <= stg_flush_reg[i-1];
            stg_sample_reg[i] <= stg_sample_reg[i-1];
        end
    end

    pdsp_delay_calc #(
        .SHIFT_USEC (SHIFT_USEC),
        .HIST_DEPTH (HISTORY_DEPTH),
        .DLY_W      (DLY_W)
    ) u_delay_calc (
        .aclk  (aclk),
        .pan   (pan_reg),
        .rate  (rate_reg),
        .dly_l (dly_l),
        .dly_r (dly_r)
    );

    assign cell_ctrl.push  = stg_vld_reg[NSTG-1] & (stg_flush_reg[NSTG-1] == ACT_PUSH);
    assign cell_ctrl.flush = stg_vld_reg[NSTG-1] & (stg_flush_reg[NSTG-1] == ACT_FLUSH);
    assign chain[0] = stg_sample_reg[NSTG-1];

    // cell k holds the sample pushed k+1 beats ago
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        pdsp_cell #(
            .TAP_INDEX (k + 1),
            .DLY_W     (DLY_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .dly_l      (dly_l),
            .dly_r      (dly_r),
            .sample_in  (chain[k]),
            .sample_out (chain[k+1]),
            .tap_l      (tap_l[k]),
            .tap_r      (tap_r[k])
        );
    end

    for (genvar k = HISTORY_DEPTH; k < NTAP; k++) begin : g_pad
        assign tap_l[k] = '0;
        assign tap_r[k] = '0;
    end

    // first level of the tap merge, registered per group of cells
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_l_next[g] = '0;
            grp_r_next[g] = '0;
            for (int j = 0; j < TAP_GROUP; j++) begin
                grp_l_next[g] = grp_l_next[g] | tap_l[g*TAP_GROUP + j];
                grp_r_next[g] = grp_r_next[g] | tap_r[g*TAP_GROUP + j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_l_reg      <= grp_l_next;
        grp_r_reg      <= grp_r_next;
        res_cur_reg    <= stg_sample_reg[NSTG-1];
        res_zero_l_reg <= (dly_l == '0);
        res_zero_r_reg <= (dly_r == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else begin
            res_vld_reg <= cell_ctrl.push;
        end
    end

    always_comb begin
        merged_l = '0;
        merged_r = '0;
        for (int g = 0; g < NGROUP; g++) begin
            merged_l = merged_l | grp_l_reg[g];
            merged_r = merged_r | grp_r_reg[g];
        end
    end

    // zero delay passes the current sample straight through
    assign out_l = res_zero_l_reg ? res_cur_reg : merged_l;
    assign out_r = res_zero_r_reg ? res_cur_reg : merged_r;

    pdsp_out_fifo #(
        .DATA_W (2 * SAMPLE_W)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_vld_reg),
        .push_data ({out_r, out_l}),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_credit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (credit_reg != '0))
        else $error("result beat without a matching credit");

    // the delay pipeline is not reset, so its outputs only count on a push beat
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.push |-> !((dly_l != '0) && (dly_r != '0)))
        else $error("both sides delayed at once");

    a_dly_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.push |->
            ((dly_l <= DLY_W'(HISTORY_DEPTH)) && (dly_r <= DLY_W'(HISTORY_DEPTH))))
        else $error("delay beyond history depth");

endmodule

`default_nettype wire

/* verif/stereo_pair_checker.sv */
// checker for the panner: mirrors the delay line from the s_ and cfg_ beats and compares m_ pairs
`timescale 1ns / 1ps

module stereo_pair_checker #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned SHIFT = 333
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire  [15:0]                          s_tdata,
    input  wire                                  s_tuser,
    input  wire                                  s_tvalid,
    input  wire                                  s_tready,
    input  wire  [31:0]                          m_tdata,
    input  wire                                  m_tvalid,
    input  wire                                  m_tready,
    input  wire                                  cfg_wen,
    input  wire  [pdsp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [pdsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                   errors,
    output int                                   pending
);

    typedef struct packed {
        pdsp_pkg::sample_t left;
        pdsp_pkg::sample_t right;
    } stereo_pair_t;

    pdsp_pkg::sample_t              history [DEPTH];
    int unsigned                    wr_pos;
    logic [pdsp_pkg::PAN_W-1:0]     pan_reg;
    logic [pdsp_pkg::RATE_W-1:0]    rate_reg;
    stereo_pair_t                   pair_q [$];

    // frames of delay for a pan magnitude at the current rate, clipped to the history
    function automatic int unsigned delay_frames(input int unsigned mag);
        longint unsigned span;
        longint unsigned d;
        span = (longint'(rate_reg) * SHIFT) / pdsp_pkg::USEC_PER_SEC;
        d = (longint'(mag) * mag * span) >> pdsp_pkg::PAN_SQ_SHIFT;
        if (d > DEPTH)
            d = DEPTH;
        return int'(d);
    endfunction

    function automatic pdsp_pkg::sample_t delayed_sample(input int unsigned d,
                                                         input pdsp_pkg::sample_t cur);
        if (d == 0)
            return cur;
        return history[(wr_pos + DEPTH - d) % DEPTH];
    endfunction

    function automatic stereo_pair_t predict_pair(input pdsp_pkg::sample_t cur);
        stereo_pair_t p;
        int unsigned  dl;
        int unsigned  dr;
        dl = 0;
        dr = 0;
        if (pan_reg[pdsp_pkg::PAN_W-1])
            dr = delay_frames((1 << pdsp_pkg::PAN_W) - pan_reg);
        else if (pan_reg != '0)
            dl = delay_frames(pan_reg);
        p.left  = delayed_sample(dl, cur);
        p.right = delayed_sample(dr, cur);
        return p;
    endfunction

    always @(posedge aclk) begin
        stereo_pair_t want;
        stereo_pair_t got;
        if (!aresetn) begin
            foreach (history[i])
                history[i] = '0;
            wr_pos   = 0;
            pan_reg  = pdsp_pkg::PAN_RESET;
            rate_reg = pdsp_pkg::RATE_RESET;
            pair_q.delete();
            errors   = 0;
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    pdsp_pkg::REG_PAN:  pan_reg  = cfg_wdata[pdsp_pkg::PAN_W-1:0];
                    pdsp_pkg::REG_RATE: rate_reg = cfg_wdata[pdsp_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == pdsp_pkg::ACT_FLUSH) begin
                    foreach (history[i])
                        history[i] = '0;
                    wr_pos = 0;
                end else begin
                    pair_q.push_back(predict_pair(s_tdata));
                    history[wr_pos] = s_tdata;
                    wr_pos = (wr_pos + 1) % DEPTH;
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16]};
                if (pair_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
                end else begin
                    want = pair_q.pop_front();
                    if (got.left !== want.left) begin
                        errors++;
                        $display("%0t: left mismatch, expected %0d got %0d",
                                 $time, want.left, got.left);
                    end
                    if (got.right !== want.right) begin
                        errors++;
                        $display("%0t: right mismatch, expected %0d got %0d",
                                 $time, want.right, got.right);
                    end
                end
            end
        end
        pending = pair_q.size();
    end

endmodule

/* verif/tb.sv */
// testbench top: drives the panner with directed and random beats and reports the verdict
`timescale 1ns / 1ps

module tb;

    localparam int unsigned HISTORY_DEPTH = 64;
    localparam int unsigned SHIFT_USEC    = 333;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE        = 12;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 50;

    logic                               aclk;
    logic                               aresetn;
    logic [15:0]                        s_tdata;
    logic                               s_tuser;
    logic                               s_tvalid;
    wire                                s_tready;
    wire  [31:0]                        m_tdata;
    wire                                m_tvalid;
    logic                               m_tready;
    logic                               cfg_wen;
    logic [pdsp_pkg::CFG_ADDR_W-1:0]    cfg_addr;
    logic [pdsp_pkg::CFG_DATA_W-1:0]    cfg_wdata;

    int          errors;
    int          pending;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned rx_count = 0;
    int unsigned idle_cycles = 0;

    phase_delay_stereo_panner #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SHIFT_USEC(SHIFT_USEC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wen(cfg_wen),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    stereo_pair_checker #(
        .DEPTH(HISTORY_DEPTH),
        .SHIFT(SHIFT_USEC)
    ) chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wen(cfg_wen),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .errors(errors),
        .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // give up when nothing moves on any port for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls per beat, one long hold when asked
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            rx_count++;
            if (rx_count % 40 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    // one input beat; tvalid stays up afterwards so back-to-back beats need no extra edge
    task automatic send_beat(input logic act, input logic [15:0] smp);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending until every pair is back, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_panning(input logic [8:0] pan, input logic [17:0] rate);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_addr  <= pdsp_pkg::REG_PAN;
        cfg_wdata <= {9'd0, pan};
        @(posedge aclk);
        cfg_addr  <= pdsp_pkg::REG_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic push_random(input int unsigned count);
        repeat (count) send_beat(pdsp_pkg::ACT_PUSH, 16'($urandom));
    endtask

    initial begin
        logic [8:0]  pan;
        logic [17:0] rate;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = pdsp_pkg::ACT_PUSH;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_addr  = pdsp_pkg::REG_PAN;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: centered, no delay on either side
        send_beat(pdsp_pkg::ACT_PUSH, 16'h7fff);
        send_beat(pdsp_pkg::ACT_PUSH, 16'h8000);
        send_beat(pdsp_pkg::ACT_PUSH, 16'h0000);
        send_beat(pdsp_pkg::ACT_PUSH, 16'hffff);
        send_beat(pdsp_pkg::ACT_PUSH, 16'h0001);
        // full pan each way at the top rate
        set_panning(9'd128, 18'd192000);
        push_random(4);
        set_panning(9'h180, 18'd192000);
        push_random(3);
        // out of range registers, delay clips at the history depth
        set_panning(9'd255, 18'h3ffff);
        push_random(2);
        set_panning(9'h100, 18'd8000);
        push_random(1);
        // flush twice, then the delayed side reads zeros
        send_beat(pdsp_pkg::ACT_FLUSH, 16'($urandom));
        send_beat(pdsp_pkg::ACT_FLUSH, 16'($urandom));
        push_random(2);
        set_panning(9'h1ff, 18'd0);
        push_random(1);
        set_panning(9'd1, 18'd8000);
        push_random(1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       pan = 9'h180;
                1:       pan = 9'd128;
                2:       pan = 9'd0;
                3:       pan = 9'($urandom);
                default: pan = 9'($urandom_range(0, 256) - 128);
            endcase
            case ($urandom_range(0, 4))
                0:       rate = 18'd8000;
                1:       rate = 18'd192000;
                2:       rate = 18'($urandom);
                default: rate = 18'($urandom_range(8000, 192000));
            endcase
            set_panning(pan, rate);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 16 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                // long receiver hold while beats keep coming, so the result queue backs up
                if (ph == 2 && i == 5)
                    hold_req = 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_beat(pdsp_pkg::ACT_FLUSH, 16'($urandom));
                else
                    send_beat(pdsp_pkg::ACT_PUSH, 16'($urandom));
            end
        end

        drain_results();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
